@@ design/mpt_pkg.sv @@
`timescale 1ns / 1ps

package mpt_pkg;

  localparam int AXIS_W     = 16;
  localparam int AXIS_BITS  = 16;
  localparam int NUM_AXES   = 3;
  localparam int TIME_W     = 32;
  localparam int IVL_W      = 16;
  localparam int SUM_W      = 32;
  localparam int MAG_W      = SUM_W / 2;
  localparam int REM_W      = MAG_W + 2;
  localparam int ROOT_STEPS = SUM_W / 2;
  localparam int CNT_W      = $clog2(ROOT_STEPS);
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [IVL_W-1:0]  POLL_INTERVAL_RST = IVL_W'(20);
  localparam logic [TIME_W-1:0] DEAD_AFTER_RST    = TIME_W'(3000);

  typedef enum logic [1:0] {
    ACT_POLL  = 2'd0,
    ACT_SNAP  = 2'd1,
    ACT_RAW   = 2'd2,
    ACT_START = 2'd3
  } action_t;

  typedef enum logic [3:0] {
    ST_SKIPPED = 4'd0,
    ST_SILENT  = 4'd1,
    ST_DEAD    = 4'd2,
    ST_SAMPLE  = 4'd3,
    ST_SNAP    = 4'd4,
    ST_SNAP_NR = 4'd5,
    ST_RAW     = 4'd6,
    ST_NO_RAW  = 4'd7,
    ST_STARTED = 4'd8
  } status_t;

  typedef enum logic {
    REG_POLL_INTERVAL = 1'b0,
    REG_DEAD_AFTER    = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [1:0]              action;
    logic [TIME_W-1:0]       now_ms;
    logic                    bus_free;
    logic                    got_accel;
    logic                    got_gyro;
    logic signed [AXIS_W-1:0] accel_x;
    logic signed [AXIS_W-1:0] accel_y;
    logic signed [AXIS_W-1:0] accel_z;
    logic signed [AXIS_W-1:0] gyro_x;
    logic signed [AXIS_W-1:0] gyro_y;
    logic signed [AXIS_W-1:0] gyro_z;
  } item_t;

  typedef struct packed {
    logic [3:0]               status;
    logic                     is_ready;
    logic [TIME_W-1:0]        stamp_ms;
    logic signed [AXIS_W-1:0] out_ax;
    logic signed [AXIS_W-1:0] out_ay;
    logic signed [AXIS_W-1:0] out_az;
    logic signed [AXIS_W-1:0] out_gx;
    logic signed [AXIS_W-1:0] out_gy;
    logic signed [AXIS_W-1:0] out_gz;
    logic [MAG_W-1:0]         accel_peak;
    logic [MAG_W-1:0]         gyro_peak;
    logic [TIME_W-1:0]        window_count;
  } result_t;

  typedef logic signed [AXIS_W-1:0] axis_t;

  function automatic axis_t sext_axis(input logic [AXIS_W-1:0] v);
    logic signed [AXIS_BITS-1:0] low;
    low = signed'(v[AXIS_BITS-1:0]);
    return AXIS_W'(low);
  endfunction

endpackage

@@ design/mpt_item_if.sv @@
`timescale 1ns / 1ps

interface mpt_item_if;
  import mpt_pkg::*;

  logic  valid;
  logic  ready;
  item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ design/mpt_result_if.sv @@
`timescale 1ns / 1ps

interface mpt_result_if;
  import mpt_pkg::*;

  logic    valid;
  logic    ready;
  result_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ design/mpt_mag.sv @@
`timescale 1ns / 1ps

module mpt_mag (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  mpt_pkg::axis_t                 x,
  input  mpt_pkg::axis_t                 y,
  input  mpt_pkg::axis_t                 z,
  output logic                           done,
  output logic [mpt_pkg::MAG_W-1:0]      mag
);
  import mpt_pkg::*;

  typedef enum logic [2:0] {
    M_IDLE = 3'b001,
    M_SQ   = 3'b010,
    M_RT   = 3'b100
  } mag_state_t;

  mag_state_t             state;
  logic [CNT_W-1:0]       cnt;
  axis_t                  axes [NUM_AXES];
  logic [SUM_W-1:0]       sum;
  logic [REM_W-1:0]       rem;
  logic [MAG_W-1:0]       root;
  logic signed [2*AXIS_W-1:0] sq;
  logic [REM_W-1:0]       rem_shift;
  logic [REM_W-1:0]       trial;
  logic                   fits;

  assign sq        = axes[0] * axes[0];
  assign rem_shift = {rem[REM_W-3:0], sum[SUM_W-1 -: 2]};
  assign trial     = {root, 2'b01};
  assign fits      = rem_shift >= trial;
  assign mag       = root;

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (state == M_RT) && (cnt == CNT_W'(ROOT_STEPS - 1));
    end
  end

  // squares accumulate one axis a cycle, then one root bit a cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= M_IDLE;
      cnt   <= '0;
    end else begin
      unique case (state)
        M_IDLE: begin
          if (start) begin
            axes[0] <= x;
            axes[1] <= y;
            axes[2] <= z;
            sum     <= '0;
            cnt     <= '0;
            state   <= M_SQ;
          end
        end
        M_SQ: begin
          sum <= sum + SUM_W'(unsigned'(sq));
          for (int i = 0; i < NUM_AXES - 1; i++) begin
            axes[i] <= axes[i+1];
          end
          if (cnt == CNT_W'(NUM_AXES - 1)) begin
            cnt   <= '0;
            rem   <= '0;
            root  <= '0;
            state <= M_RT;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        M_RT: begin
          sum <= {sum[SUM_W-3:0], 2'b00};
          if (fits) begin
            rem  <= rem_shift - trial;
            root <= {root[MAG_W-2:0], 1'b1};
          end else begin
            rem  <= rem_shift;
            root <= {root[MAG_W-2:0], 1'b0};
          end
          if (cnt == CNT_W'(ROOT_STEPS - 1)) begin
            state <= M_IDLE;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        default: state <= M_IDLE;
      endcase
    end
  end

endmodule

@@ design/motion_peak_tracker_watchdog_core.sv @@
`timescale 1ns / 1ps

// motion peak tracker with sensor watchdog
// item channel: one request per action (poll, snapshot, raw take, start),
// accepted when valid and ready are both high; one result per request on the
// result channel, held until the receiver takes it
// apb port: poll interval at byte 0, dead-after time at byte 4; pready is
// always high; registers are to be written only while no request is in
// flight, which the user must ensure: the block does not enforce it
// a poll that carries data first passes the magnitude units (the squares of
// the three axes, then one root bit per cycle); accel and gyro run in parallel
// every other request skips them; each result goes from the staging register
// to the result register once the output is free; one request at a time: the
// next is taken only after the last result has reached the result register
// a result waiting in the output register does not block the next request;
// only handing over the following result waits for the receiver
// reset: synchronous, clears all tracker state, output empty, poll interval
// back to 20 ms and dead-after back to 3000 ms; the block is not ready until
// a start request

module motion_peak_tracker_watchdog_core (
  input  logic                                clk,
  input  logic                                rst,
  mpt_item_if.sink                            item,
  mpt_result_if.source                        result,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [mpt_pkg::CFG_ADDR_W-1:0]      paddr,
  input  logic [mpt_pkg::CFG_DATA_W-1:0]      pwdata,
  output logic [mpt_pkg::CFG_DATA_W-1:0]      prdata,
  output logic                                pready
);
  import mpt_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_CALC = 3'b010,
    S_PUSH = 3'b100
  } state_t;

  state_t            state;
  logic [IVL_W-1:0]  poll_ivl;
  logic [TIME_W-1:0] dead_limit;

  logic              ready_flag;
  logic [TIME_W-1:0] last_poll_time;
  logic [TIME_W-1:0] last_good_time;
  axis_t             latest_accel [NUM_AXES];
  axis_t             latest_gyro [NUM_AXES];
  logic [MAG_W-1:0]  accel_peak_store;
  logic [MAG_W-1:0]  gyro_peak_store;
  logic [TIME_W-1:0] sample_counter;
  logic [TIME_W-1:0] raw_time;
  logic              raw_pending;

  result_t           res;
  result_t           res_next;
  logic              accept;
  logic              out_free;
  logic              cfg_write;
  reg_idx_t          cfg_idx;

  logic [TIME_W-1:0] poll_gap;
  logic [TIME_W-1:0] silence;
  logic              poll_ok;
  logic              is_dead;
  logic              has_data;
  logic              take_sample;
  logic              ready_next;

  axis_t             ax, ay, az, gx, gy, gz;
  logic              accel_start, gyro_start;
  logic              accel_done, gyro_done;
  logic [MAG_W-1:0]  accel_mag, gyro_mag;
  logic              accel_wait, gyro_wait;
  logic              use_accel, use_gyro;

  assign accept   = item.valid && item.ready;
  assign item.ready = (state == S_IDLE);
  assign out_free = !result.valid || result.ready;
  assign pready   = 1'b1;
  assign cfg_idx  = reg_idx_t'(paddr[2]);
  assign cfg_write = psel && penable && pwrite && pready;

  always_comb begin
    unique case (cfg_idx)
      REG_POLL_INTERVAL: prdata = CFG_DATA_W'(poll_ivl);
      REG_DEAD_AFTER:    prdata = CFG_DATA_W'(dead_limit);
      default:           prdata = '0;
    endcase
  end

  assign ax = sext_axis(item.data.accel_x);
  assign ay = sext_axis(item.data.accel_y);
  assign az = sext_axis(item.data.accel_z);
  assign gx = sext_axis(item.data.gyro_x);
  assign gy = sext_axis(item.data.gyro_y);
  assign gz = sext_axis(item.data.gyro_z);

  assign poll_gap = item.data.now_ms - last_poll_time;
  assign silence  = item.data.now_ms - last_good_time;
  assign poll_ok  = ready_flag && (poll_gap >= TIME_W'(poll_ivl))
                    && item.data.bus_free;
  assign is_dead  = (last_good_time != '0) && (silence > dead_limit);
  assign has_data = item.data.got_accel || item.data.got_gyro;
  assign take_sample = (action_t'(item.data.action) == ACT_POLL) && poll_ok && has_data;

  assign accel_start = accept && take_sample && item.data.got_accel;
  assign gyro_start  = accept && take_sample && item.data.got_gyro;

  always_comb begin
    res_next   = '0;
    ready_next = ready_flag;
    unique case (action_t'(item.data.action))
      ACT_POLL: begin
        if (!poll_ok) begin
          res_next.status = ST_SKIPPED;
        end else if (!has_data) begin
          if (is_dead) begin
            res_next.status = ST_DEAD;
            ready_next      = 1'b0;
          end else begin
            res_next.status = ST_SILENT;
          end
        end else begin
          res_next.status = ST_SAMPLE;
        end
      end
      ACT_SNAP: begin
        if (!ready_flag) begin
          res_next.status = ST_SNAP_NR;
        end else begin
          res_next.status       = ST_SNAP;
          res_next.out_ax       = latest_accel[0];
          res_next.out_ay       = latest_accel[1];
          res_next.out_az       = latest_accel[2];
          res_next.out_gx       = latest_gyro[0];
          res_next.out_gy       = latest_gyro[1];
          res_next.out_gz       = latest_gyro[2];
          res_next.accel_peak   = accel_peak_store;
          res_next.gyro_peak    = gyro_peak_store;
          res_next.window_count = sample_counter;
        end
      end
      ACT_RAW: begin
        if (!raw_pending) begin
          res_next.status = ST_NO_RAW;
        end else begin
          res_next.status   = ST_RAW;
          res_next.stamp_ms = raw_time;
          res_next.out_ax   = latest_accel[0];
          res_next.out_ay   = latest_accel[1];
          res_next.out_az   = latest_accel[2];
          res_next.out_gx   = latest_gyro[0];
          res_next.out_gy   = latest_gyro[1];
          res_next.out_gz   = latest_gyro[2];
        end
      end
      ACT_START: begin
        res_next.status = ST_STARTED;
        ready_next      = 1'b1;
      end
      default: res_next.status = ST_SKIPPED;
    endcase
    res_next.is_ready = ready_next;
  end

  mpt_mag u_accel_mag (
    .clk   (clk),
    .rst   (rst),
    .start (accel_start),
    .x     (ax),
    .y     (ay),
    .z     (az),
    .done  (accel_done),
    .mag   (accel_mag)
  );

  mpt_mag u_gyro_mag (
    .clk   (clk),
    .rst   (rst),
    .start (gyro_start),
    .x     (gx),
    .y     (gy),
    .z     (gz),
    .done  (gyro_done),
    .mag   (gyro_mag)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      poll_ivl   <= POLL_INTERVAL_RST;
      dead_limit <= DEAD_AFTER_RST;
    end else if (cfg_write) begin
      unique case (cfg_idx)
        REG_POLL_INTERVAL: poll_ivl   <= pwdata[IVL_W-1:0];
        REG_DEAD_AFTER:    dead_limit <= pwdata[TIME_W-1:0];
        default:           ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if ((state == S_PUSH) && out_free) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      ready_flag       <= 1'b0;
      last_poll_time   <= '0;
      last_good_time   <= '0;
      accel_peak_store <= '0;
      gyro_peak_store  <= '0;
      sample_counter   <= '0;
      raw_time         <= '0;
      raw_pending      <= 1'b0;
      accel_wait       <= 1'b0;
      gyro_wait        <= 1'b0;
      use_accel        <= 1'b0;
      use_gyro         <= 1'b0;
      for (int i = 0; i < NUM_AXES; i++) begin
        latest_accel[i] <= '0;
        latest_gyro[i]  <= '0;
      end
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            res        <= res_next;
            ready_flag <= ready_next;
            unique case (action_t'(item.data.action))
              ACT_POLL: begin
                if (poll_ok) begin
                  last_poll_time <= item.data.now_ms;
                end
                if (take_sample) begin
                  last_good_time <= item.data.now_ms;
                  sample_counter <= sample_counter + 1'b1;
                  raw_time       <= item.data.now_ms;
                  raw_pending    <= 1'b1;
                  if (item.data.got_accel) begin
                    latest_accel[0] <= ax;
                    latest_accel[1] <= ay;
                    latest_accel[2] <= az;
                  end
                  if (item.data.got_gyro) begin
                    latest_gyro[0] <= gx;
                    latest_gyro[1] <= gy;
                    latest_gyro[2] <= gz;
                  end
                end
              end
              ACT_SNAP: begin
                if (ready_flag) begin
                  accel_peak_store <= '0;
                  gyro_peak_store  <= '0;
                  sample_counter   <= '0;
                end
              end
              ACT_RAW: begin
                raw_pending <= 1'b0;
              end
              ACT_START: begin
                last_good_time <= item.data.now_ms;
              end
              default: ;
            endcase
            if (take_sample) begin
              accel_wait <= item.data.got_accel;
              gyro_wait  <= item.data.got_gyro;
              use_accel  <= item.data.got_accel;
              use_gyro   <= item.data.got_gyro;
              state      <= S_CALC;
            end else begin
              state <= S_PUSH;
            end
          end
        end
        S_CALC: begin
          if (accel_done) begin
            accel_wait <= 1'b0;
          end
          if (gyro_done) begin
            gyro_wait <= 1'b0;
          end
          if (!accel_wait && !gyro_wait) begin
            if (use_accel && (accel_mag > accel_peak_store)) begin
              accel_peak_store <= accel_mag;
            end
            if (use_gyro && (gyro_mag > gyro_peak_store)) begin
              gyro_peak_store <= gyro_mag;
            end
            state <= S_PUSH;
          end
        end
        S_PUSH: begin
          if (out_free) begin
            result.data <= res;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ design/mpt_checker.sv @@
`timescale 1ns / 1ps

module mpt_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      item_valid,
  input logic                      item_ready,
  input logic                      result_valid,
  input logic                      result_ready,
  input logic [3:0]                status,
  input logic                      is_ready,
  input logic [mpt_pkg::MAG_W-1:0] accel_peak,
  input logic [mpt_pkg::MAG_W-1:0] gyro_peak,
  input logic [mpt_pkg::TIME_W-1:0] window_count
);
  import mpt_pkg::*;

  // a held result keeps its status
  assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(status))
    else $error("result changed while stalled");

  // one request at a time
  assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready |=> !item_ready)
    else $error("request accepted while busy");

  assert property (@(posedge clk) disable iff (rst)
    result_valid && (status == ST_STARTED || status == ST_SAMPLE || status == ST_SNAP)
    |-> is_ready)
    else $error("ready flag low after start, sample or snapshot");

  assert property (@(posedge clk) disable iff (rst)
    result_valid && (status == ST_DEAD || status == ST_SNAP_NR) |-> !is_ready)
    else $error("ready flag high after dead or refused snapshot");

  assert property (@(posedge clk) disable iff (rst)
    result_valid && status != ST_SNAP
    |-> accel_peak == '0 && gyro_peak == '0 && window_count == '0)
    else $error("peak data outside snapshot");

endmodule

bind motion_peak_tracker_watchdog_core mpt_checker u_mpt_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item.valid),
  .item_ready   (item.ready),
  .result_valid (result.valid),
  .result_ready (result.ready),
  .status       (result.data.status),
  .is_ready     (result.data.is_ready),
  .accel_peak   (result.data.accel_peak),
  .gyro_peak    (result.data.gyro_peak),
  .window_count (result.data.window_count)
);

@@ bench/motion_peak_tracker_watchdog_core_tb.sv @@
`timescale 1ns / 1ps

module motion_peak_tracker_watchdog_core_tb;
  import mpt_pkg::*;

  localparam logic [IVL_W-1:0]  IVL_SET  [7] = '{16'd20, 16'd0, 16'hffff, 16'd1, 16'd37,
                                                 16'hffff, 16'd0};
  localparam logic [TIME_W-1:0] DEAD_SET [7] = '{32'd3000, 32'd0, 32'hffff_ffff, 32'd1,
                                                 32'd500, 32'd0, 32'hffff_ffff};

  logic                  clk;
  logic                  rst;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  mpt_item_if   item_ch ();
  mpt_result_if result_ch ();

  motion_peak_tracker_watchdog_core dut (
    .clk     (clk),
    .rst     (rst),
    .item    (item_ch),
    .result  (result_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // tracker copy kept by the bench
  logic              trk_ready;
  logic [TIME_W-1:0] trk_last_poll;
  logic [TIME_W-1:0] trk_last_good;
  axis_t             trk_accel [3];
  axis_t             trk_gyro [3];
  logic [MAG_W-1:0]  trk_accel_peak;
  logic [MAG_W-1:0]  trk_gyro_peak;
  logic [TIME_W-1:0] trk_samples;
  logic [TIME_W-1:0] trk_raw_time;
  logic              trk_raw_pending;
  logic [IVL_W-1:0]  cfg_poll_ivl;
  logic [TIME_W-1:0] cfg_dead_after;

  result_t           awaited_reports [$];
  int                bad_count;
  int                report_idx;
  int                stall_pct;
  logic [TIME_W-1:0] stim_ms;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      result_ch.ready <= !rst && ($urandom_range(0, 99) >= stall_pct);
    end
  end

  task automatic log_mismatch(input string msg);
    bad_count++;
    if (bad_count <= 10) begin
      $display("%s", msg);
    end
  endtask

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      log_mismatch($sformatf("report %0d %s: expected %h got %h", report_idx, name, want, got));
    end
  endtask

  always @(posedge clk) begin : check_reports
    result_t want;
    result_t got;
    if (!rst && result_ch.valid && result_ch.ready) begin
      got = result_ch.data;
      if (awaited_reports.size() == 0) begin
        log_mismatch($sformatf("report %0d arrived with nothing awaited", report_idx));
      end else begin
        want = awaited_reports.pop_front();
        compare_field("status", 32'(want.status), 32'(got.status));
        compare_field("is_ready", 32'(want.is_ready), 32'(got.is_ready));
        compare_field("stamp_ms", want.stamp_ms, got.stamp_ms);
        compare_field("out_ax", 32'(want.out_ax), 32'(got.out_ax));
        compare_field("out_ay", 32'(want.out_ay), 32'(got.out_ay));
        compare_field("out_az", 32'(want.out_az), 32'(got.out_az));
        compare_field("out_gx", 32'(want.out_gx), 32'(got.out_gx));
        compare_field("out_gy", 32'(want.out_gy), 32'(got.out_gy));
        compare_field("out_gz", 32'(want.out_gz), 32'(got.out_gz));
        compare_field("accel_peak", 32'(want.accel_peak), 32'(got.accel_peak));
        compare_field("gyro_peak", 32'(want.gyro_peak), 32'(got.gyro_peak));
        compare_field("window_count", want.window_count, got.window_count);
      end
      report_idx++;
    end
  end

  function automatic logic [MAG_W-1:0] vec_mag(input axis_t a, input axis_t b, input axis_t c);
    longint           sq;
    logic [MAG_W-1:0] root;
    logic [MAG_W-1:0] trial;
    sq = longint'(a) * a + longint'(b) * b + longint'(c) * c;
    root = '0;
    for (int bit_n = MAG_W - 1; bit_n >= 0; bit_n--) begin
      trial = root | (MAG_W'(1) << bit_n);
      if (longint'(trial) * longint'(trial) <= sq) begin
        root = trial;
      end
    end
    return root;
  endfunction

  function automatic result_t with_latest(input result_t rep);
    rep.out_ax = trk_accel[0];
    rep.out_ay = trk_accel[1];
    rep.out_az = trk_accel[2];
    rep.out_gx = trk_gyro[0];
    rep.out_gy = trk_gyro[1];
    rep.out_gz = trk_gyro[2];
    return rep;
  endfunction

  function automatic result_t track_request(input item_t req);
    result_t           rep;
    logic [TIME_W-1:0] since_poll;
    logic [TIME_W-1:0] since_good;
    logic [MAG_W-1:0]  mag;
    rep = '0;
    since_poll = req.now_ms - trk_last_poll;
    since_good = req.now_ms - trk_last_good;
    case (action_t'(req.action))
      ACT_POLL: begin
        if (trk_ready && since_poll >= {16'b0, cfg_poll_ivl} && req.bus_free) begin
          trk_last_poll = req.now_ms;
          if (!req.got_accel && !req.got_gyro) begin
            if (trk_last_good != 0 && since_good > cfg_dead_after) begin
              trk_ready = 1'b0;
              rep.status = ST_DEAD;
            end else begin
              rep.status = ST_SILENT;
            end
          end else begin
            trk_last_good = req.now_ms;
            if (req.got_accel) begin
              trk_accel[0] = req.accel_x;
              trk_accel[1] = req.accel_y;
              trk_accel[2] = req.accel_z;
              mag = vec_mag(req.accel_x, req.accel_y, req.accel_z);
              if (mag > trk_accel_peak) begin
                trk_accel_peak = mag;
              end
            end
            if (req.got_gyro) begin
              trk_gyro[0] = req.gyro_x;
              trk_gyro[1] = req.gyro_y;
              trk_gyro[2] = req.gyro_z;
              mag = vec_mag(req.gyro_x, req.gyro_y, req.gyro_z);
              if (mag > trk_gyro_peak) begin
                trk_gyro_peak = mag;
              end
            end
            trk_samples = trk_samples + 1;
            trk_raw_time = req.now_ms;
            trk_raw_pending = 1'b1;
            rep.status = ST_SAMPLE;
          end
        end else begin
          rep.status = ST_SKIPPED;
        end
      end
      ACT_SNAP: begin
        if (!trk_ready) begin
          rep.status = ST_SNAP_NR;
        end else begin
          rep = with_latest(rep);
          rep.accel_peak = trk_accel_peak;
          rep.gyro_peak = trk_gyro_peak;
          rep.window_count = trk_samples;
          trk_accel_peak = '0;
          trk_gyro_peak = '0;
          trk_samples = '0;
          rep.status = ST_SNAP;
        end
      end
      ACT_RAW: begin
        if (!trk_raw_pending) begin
          rep.status = ST_NO_RAW;
        end else begin
          rep = with_latest(rep);
          rep.stamp_ms = trk_raw_time;
          trk_raw_pending = 1'b0;
          rep.status = ST_RAW;
        end
      end
      default: begin
        trk_ready = 1'b1;
        trk_last_good = req.now_ms;
        rep.status = ST_STARTED;
      end
    endcase
    rep.is_ready = trk_ready;
    return rep;
  endfunction

  task automatic send_request(input item_t req);
    if ($urandom_range(0, 99) < stall_pct) begin
      item_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < stall_pct);
    end
    item_ch.valid <= 1'b1;
    item_ch.data <= req;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
    awaited_reports.push_back(track_request(req));
  endtask

  task automatic cfg_write(input reg_idx_t idx, input logic [31:0] value);
    logic [31:0] want;
    item_ch.valid <= 1'b0;
    while (awaited_reports.size() != 0) @(posedge clk);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (idx == REG_POLL_INTERVAL) begin
      cfg_poll_ivl = value[IVL_W-1:0];
      want = {16'b0, value[IVL_W-1:0]};
    end else begin
      cfg_dead_after = value;
      want = value;
    end
    // read back
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== want) begin
      log_mismatch($sformatf("register %0d read: expected %h got %h", idx, want, prdata));
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic item_t mk_req(input action_t act, input logic [31:0] now,
                                   input logic bus, input logic ga, input logic gg,
                                   input int ax, input int ay, input int az,
                                   input int gx, input int gy, input int gz);
    item_t req;
    req.action = act;
    req.now_ms = now;
    req.bus_free = bus;
    req.got_accel = ga;
    req.got_gyro = gg;
    req.accel_x = axis_t'(ax);
    req.accel_y = axis_t'(ay);
    req.accel_z = axis_t'(az);
    req.gyro_x = axis_t'(gx);
    req.gyro_y = axis_t'(gy);
    req.gyro_z = axis_t'(gz);
    return req;
  endfunction

  function automatic axis_t rand_axis();
    case ($urandom_range(0, 7))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return '0;
      3: return axis_t'($urandom_range(0, 16) - 8);
      default: return axis_t'($urandom);
    endcase
  endfunction

  function automatic item_t gen_request();
    item_t       req;
    int          pick;
    logic [31:0] gap;
    req.accel_x = rand_axis();
    req.accel_y = rand_axis();
    req.accel_z = rand_axis();
    req.gyro_x = rand_axis();
    req.gyro_y = rand_axis();
    req.gyro_z = rand_axis();
    req.action = ACT_POLL;
    req.bus_free = 1'b1;
    req.got_accel = 1'b1;
    req.got_gyro = 1'b1;
    req.now_ms = stim_ms;
    pick = $urandom_range(0, 99);
    if (!trk_ready && $urandom_range(0, 3) == 0) begin
      pick = 0;
    end
    if (pick < 4) begin
      stim_ms = stim_ms + $urandom_range(0, 40);
      req.action = ACT_START;
      req.now_ms = stim_ms;
    end else if (pick < 60) begin
      stim_ms = stim_ms + cfg_poll_ivl + $urandom_range(0, 25);
      req.now_ms = stim_ms;
      req.bus_free = ($urandom_range(0, 9) != 0);
      case ($urandom_range(0, 5))
        0: req.got_gyro = 1'b0;
        1: req.got_accel = 1'b0;
        2: begin
          req.got_accel = 1'b0;
          req.got_gyro = 1'b0;
        end
        default: ;
      endcase
    end else if (pick < 68) begin
      req.action = ACT_SNAP;
      req.now_ms = $urandom;
    end else if (pick < 76) begin
      req.action = ACT_RAW;
      req.now_ms = $urandom;
    end else if (pick < 86) begin
      // too soon, up to the interval boundary
      req.now_ms = stim_ms + $urandom_range(0, cfg_poll_ivl);
    end else if (pick < 93) begin
      // silence around the dead-after threshold
      gap = cfg_dead_after - 1 + $urandom_range(0, 2);
      if (gap < cfg_poll_ivl) begin
        gap = cfg_poll_ivl + $urandom_range(0, 2);
      end
      stim_ms = stim_ms + gap;
      req.now_ms = stim_ms;
      req.got_accel = 1'b0;
      req.got_gyro = 1'b0;
    end else begin
      req.action = 2'($urandom);
      req.now_ms = $urandom;
      req.bus_free = 1'($urandom);
      req.got_accel = 1'($urandom);
      req.got_gyro = 1'($urandom);
    end
    return req;
  endfunction

  task automatic test_before_start();
    send_request(mk_req(ACT_POLL, 32'd100, 1'b1, 1'b1, 1'b1, 5, 5, 5, 5, 5, 5));
    send_request(mk_req(ACT_SNAP, 32'd0, 1'b0, 1'b0, 1'b0, 0, 0, 0, 0, 0, 0));
    send_request(mk_req(ACT_RAW, 32'd0, 1'b0, 1'b0, 1'b0, 0, 0, 0, 0, 0, 0));
    send_request(mk_req(ACT_START, 32'd0, 1'b0, 1'b0, 1'b0, 0, 0, 0, 0, 0, 0));
    send_request(mk_req(ACT_POLL, 32'd20, 1'b1, 1'b0, 1'b0, 0, 0, 0, 0, 0, 0));
    // last good time zero never declares dead
    send_request(mk_req(ACT_POLL, 32'd5000, 1'b1, 1'b0, 1'b0, 0, 0, 0, 0, 0, 0));
    send_request(mk_req(ACT_SNAP, 32'd0, 1'b0, 1'b0, 1'b0, 0, 0, 0, 0, 0, 0));
  endtask

  task automatic test_sampling_peaks();
    send_request(mk_req(ACT_POLL, 32'd5020, 1'b1, 1'b1, 1'b1, -32768, -32768,
                        -32768, 32767, 32767, 32767));
    send_request(mk_req(ACT_POLL, 32'd5040, 1'b1, 1'b1, 1'b0, 1, -2, 2, 9, 9, 9));
    send_request(mk_req(ACT_POLL, 32'd5060, 1'b1, 1'b0, 1'b1, -7, 7, -7, 0, 0, 0));
    send_request(mk_req(ACT_POLL, 32'd5070, 1'b1, 1'b1, 1'b1, 3, 3, 3, 3, 3, 3));
    send_request(mk_req(ACT_POLL, 32'd5080, 1'b0, 1'b1, 1'b1, 4, 4, 4, 4, 4, 4));
    send_request(mk_req(ACT_RAW, 32'd0, 1'b0, 1'b0, 1'b0, 0, 0, 0, 0, 0, 0));
    send_request(mk_req(ACT_RAW, 32'd0, 1'b0, 1'b0, 1'b0, 0, 0, 0, 0, 0, 0));
    send_request(mk_req(ACT_SNAP, 32'd0, 1'b0, 1'b0, 1'b0, 0, 0, 0, 0, 0, 0));
  endtask

  task automatic test_watchdog();
    send_request(mk_req(ACT_START, 32'd6000, 1'b0, 1'b0, 1'b0, 0, 0, 0, 0, 0, 0));
    send_request(mk_req(ACT_POLL, 32'd9000, 1'b1, 1'b0, 1'b0, 0, 0, 0, 0, 0, 0));
    send_request(mk_req(ACT_POLL, 32'd9020, 1'b1, 1'b0, 1'b0, 0, 0, 0, 0, 0, 0));
    send_request(mk_req(ACT_SNAP, 32'd0, 1'b0, 1'b0, 1'b0, 0, 0, 0, 0, 0, 0));
    send_request(mk_req(ACT_POLL, 32'd9100, 1'b1, 1'b1, 1'b1, 1, 1, 1, 1, 1, 1));
    send_request(mk_req(ACT_RAW, 32'd0, 1'b0, 1'b0, 1'b0, 0, 0, 0, 0, 0, 0));
  endtask

  task automatic test_time_wrap();
    send_request(mk_req(ACT_START, 32'hffff_fff0, 1'b0, 1'b0, 1'b0, 0, 0, 0, 0, 0, 0));
    send_request(mk_req(ACT_POLL, 32'hffff_fff8, 1'b1, 1'b0, 1'b0, 0, 0, 0, 0, 0, 0));
    send_request(mk_req(ACT_POLL, 32'h0000_0005, 1'b1, 1'b1, 1'b1, 2, 2, 2, 2, 2, 2));
    send_request(mk_req(ACT_POLL, 32'h0000_000c, 1'b1, 1'b1, 1'b1, -300, 400, 0,
                        1000, -2000, 2000));
    send_request(mk_req(ACT_RAW, 32'd0, 1'b0, 1'b0, 1'b0, 0, 0, 0, 0, 0, 0));
    send_request(mk_req(ACT_POLL, 32'h0000_0bc5, 1'b1, 1'b0, 1'b0, 0, 0, 0, 0, 0, 0));
  endtask

  task automatic test_random_traffic();
    for (int ph = 0; ph < 7; ph++) begin
      cfg_write(REG_POLL_INTERVAL, {16'b0, IVL_SET[ph]});
      cfg_write(REG_DEAD_AFTER, DEAD_SET[ph]);
      stall_pct = (ph == 3) ? 0 : 19;
      stim_ms = $urandom;
      for (int n = 0; n < 150; n++) begin
        send_request(gen_request());
      end
    end
    stall_pct = 19;
  endtask

  initial begin
    rst <= 1'b1;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    item_ch.valid <= 1'b0;
    item_ch.data <= '0;
    stall_pct = 19;
    bad_count = 0;
    report_idx = 0;
    stim_ms = '0;
    trk_ready = 1'b0;
    trk_last_poll = '0;
    trk_last_good = '0;
    for (int i = 0; i < NUM_AXES; i++) begin
      trk_accel[i] = '0;
      trk_gyro[i] = '0;
    end
    trk_accel_peak = '0;
    trk_gyro_peak = '0;
    trk_samples = '0;
    trk_raw_time = '0;
    trk_raw_pending = 1'b0;
    cfg_poll_ivl = POLL_INTERVAL_RST;
    cfg_dead_after = DEAD_AFTER_RST;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_before_start();
    test_sampling_peaks();
    test_watchdog();
    test_time_wrap();
    test_random_traffic();
    item_ch.valid <= 1'b0;
    while (awaited_reports.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (bad_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
design/mpt_pkg.sv
design/mpt_item_if.sv
design/mpt_result_if.sv
design/mpt_mag.sv
design/motion_peak_tracker_watchdog_core.sv
design/mpt_checker.sv
bench/motion_peak_tracker_watchdog_core_tb.sv
